FILE: design/ppfh_pkg.sv
// ----------------------------------------------------------------------------
// ppfh_pkg
// Shared constants and helpers for the peak pair fingerprint hasher.
// ----------------------------------------------------------------------------
package ppfh_pkg;

  localparam int FAN_DEF        = 5;
  localparam int HEX_DIGITS_DEF = 10;
  localparam int TIME_BITS_DEF  = 16;
  localparam int FREQ_BITS_DEF  = 12;

  localparam int HASH_W      = 40;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA = 2'd1;

  localparam logic [CFG_W-1:0] MIN_DELTA_RST = 16'd0;
  localparam logic [CFG_W-1:0] MAX_DELTA_RST = 16'd200;

  localparam logic [31:0] SHA_H0 = 32'h67452301;
  localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
  localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
  localparam logic [31:0] SHA_H3 = 32'h10325476;
  localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;
  localparam logic [31:0] SHA_K0 = 32'h5A827999;
  localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

  // Number of decimal digits needed for the largest value of a given width.
  function automatic int dec_digits(input int w);
    longint m;
    int n;
    m = (longint'(1) << w) - 1;
    n = 1;
    while (m >= 10) begin
      m = m / 10;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

FILE: design/peak_pair_fingerprint_hasher.sv
// After a peak that starts no pairing pass, the front goes through its done state (held there
// while a pending order-error job waits for the queue) before it takes the next peak.
// Each hashed pair goes through binary to decimal conversion of three numbers, bytes shifted
// one at a time into the block, and 80 rounds. Throughput is set by the single SHA-1 round
// unit; the front keeps issuing jobs into a four-entry queue, while it has room, as hashing runs.
// Reset: synchronous, active low; window empty, delta bounds 0 and 200.
// ----------------------------------------------------------------------------
// peak_pair_fingerprint_hasher
// Pairs time-ordered spectral peaks and emits truncated SHA-1 fingerprints.
// ----------------------------------------------------------------------------
module peak_pair_fingerprint_hasher #(
  parameter int FAN             = ppfh_pkg::FAN_DEF,
  parameter int HASH_HEX_DIGITS = ppfh_pkg::HEX_DIGITS_DEF,
  parameter int TIME_BITS       = ppfh_pkg::TIME_BITS_DEF,
  parameter int FREQ_BITS       = ppfh_pkg::FREQ_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppfh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppfh_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [FREQ_BITS-1:0]           in_freq_bin,
  input  logic [TIME_BITS-1:0]           in_time_frame,
  input  logic                           in_last_peak,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ppfh_pkg::HASH_W-1:0]    out_hash_value,
  output logic [TIME_BITS-1:0]           out_anchor_time,
  output logic                           out_order_error,
  output logic                           out_last_result
);

  import ppfh_pkg::*;

  localparam int JW = 2 * FREQ_BITS + 2 * TIME_BITS + 2;

  logic [CFG_W-1:0] min_delta_r;
  logic [CFG_W-1:0] max_delta_r;
  logic             fq_valid;
  logic             fq_ready;
  logic [JW-1:0]    fq_data;
  logic             qb_valid;
  logic             qb_ready;
  logic [JW-1:0]    qb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delta_r <= MIN_DELTA_RST;
      max_delta_r <= MAX_DELTA_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIN_DELTA) begin
        min_delta_r <= cfg_data;
      end else if (cfg_index == CFG_MAX_DELTA) begin
        max_delta_r <= cfg_data;
      end
    end
  end

  ppfh_front #(
    .FAN       (FAN),
    .TIME_BITS (TIME_BITS),
    .FREQ_BITS (FREQ_BITS),
    .JW        (JW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_freq_bin   (in_freq_bin),
    .in_time_frame (in_time_frame),
    .in_last_peak  (in_last_peak),
    .min_delta     (min_delta_r),
    .max_delta     (max_delta_r),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_data        (fq_data)
  );

  ppfh_queue #(
    .W     (JW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  ppfh_back #(
    .TIME_BITS  (TIME_BITS),
    .FREQ_BITS  (FREQ_BITS),
    .HEX_DIGITS (HASH_HEX_DIGITS),
    .JW         (JW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (qb_valid),
    .q_ready         (qb_ready),
    .q_data          (qb_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value),
    .out_anchor_time (out_anchor_time),
    .out_order_error (out_order_error),
    .out_last_result (out_last_result)
  );

endmodule

FILE: design/ppfh_queue.sv
// ----------------------------------------------------------------------------
// ppfh_queue
// Small first-in first-out queue of pair jobs between front and back.
// ----------------------------------------------------------------------------
module ppfh_queue #(
  parameter int W     = 58,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/ppfh_front.sv
// ----------------------------------------------------------------------------
// ppfh_front
// Accepts peaks, checks their order, keeps the window and issues pair and order-error jobs.
// ----------------------------------------------------------------------------
module ppfh_front #(
  parameter int FAN       = ppfh_pkg::FAN_DEF,
  parameter int TIME_BITS = ppfh_pkg::TIME_BITS_DEF,
  parameter int FREQ_BITS = ppfh_pkg::FREQ_BITS_DEF,
  parameter int JW        = 2 * FREQ_BITS + 2 * TIME_BITS + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [FREQ_BITS-1:0]       in_freq_bin,
  input  logic [TIME_BITS-1:0]       in_time_frame,
  input  logic                       in_last_peak,
  input  logic [ppfh_pkg::CFG_W-1:0] min_delta,
  input  logic [ppfh_pkg::CFG_W-1:0] max_delta,
  output logic                       q_valid,
  input  logic                       q_ready,
  output logic [JW-1:0]              q_data
);

  import ppfh_pkg::*;

  localparam int CW = $clog2(FAN + 1);
  localparam int IW = $clog2(FAN);
  localparam int DW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  typedef enum logic [1:0] {S_IDLE, S_PAIR, S_DONE} state_t;

  state_t               state_r;
  logic [CW-1:0]        cnt_r;
  logic [IW-1:0]        j_r;
  logic                 last_r;
  logic [FREQ_BITS-1:0] wf_r [FAN];
  logic [TIME_BITS-1:0] wt_r [FAN];
  logic [FREQ_BITS-1:0] nf_r;
  logic [TIME_BITS-1:0] nt_r;
  logic [JW-2:0]        pend_r;
  logic                 pend_v_r;

  logic [CW-1:0]        cnt_inc;
  logic                 bad;
  logic [FREQ_BITS-1:0] fj;
  logic [TIME_BITS-1:0] tj;
  logic [TIME_BITS-1:0] delta;
  logic                 qual;
  logic                 stall;
  logic                 pass_end;

  assign cnt_inc  = cnt_r + 1'b1;
  assign bad      = (cnt_r != '0) &&
                    ((in_time_frame < nt_r) || ((in_time_frame == nt_r) && (in_freq_bin < nf_r)));
  assign fj       = wf_r[j_r];
  assign tj       = wt_r[j_r];
  assign delta    = tj - wt_r[0];
  assign qual     = (tj >= wt_r[0]) && (DW'(delta) >= DW'(min_delta)) &&
                    (DW'(delta) <= DW'(max_delta));
  assign stall    = qual && pend_v_r && !q_ready;
  assign pass_end = (CW'(j_r) == cnt_r - CW'(1));

  assign in_ready = (state_r == S_IDLE);
  assign q_valid  = ((state_r == S_PAIR) && qual && pend_v_r) ||
                    ((state_r == S_DONE) && pend_v_r);
  assign q_data   = {(state_r == S_DONE), pend_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      j_r      <= '0;
      last_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= in_last_peak;
            if (bad) begin
              pend_r   <= {1'b1, {(JW - 2){1'b0}}};
              pend_v_r <= 1'b1;
              if (in_last_peak && (cnt_r >= CW'(2))) begin
                j_r     <= IW'(1);
                state_r <= S_PAIR;
              end else begin
                if (in_last_peak) begin
                  cnt_r <= '0;
                end
                state_r <= S_DONE;
              end
            end else begin
              wf_r[cnt_r[IW-1:0]] <= in_freq_bin;
              wt_r[cnt_r[IW-1:0]] <= in_time_frame;
              nf_r                <= in_freq_bin;
              nt_r                <= in_time_frame;
              if ((cnt_inc == CW'(FAN)) || (in_last_peak && (cnt_inc >= CW'(2)))) begin
                cnt_r   <= cnt_inc;
                j_r     <= IW'(1);
                state_r <= S_PAIR;
              end else begin
                cnt_r   <= in_last_peak ? '0 : cnt_inc;
                state_r <= S_DONE;
              end
            end
          end
        end
        S_PAIR: begin
          if (!stall) begin
            if (qual) begin
              pend_r   <= {1'b0, wt_r[0], delta, fj, wf_r[0]};
              pend_v_r <= 1'b1;
            end
            if (pass_end) begin
              for (int k = 0; k < FAN - 1; k++) begin
                wf_r[k] <= wf_r[k+1];
                wt_r[k] <= wt_r[k+1];
              end
              if (last_r && (cnt_r - CW'(1) >= CW'(2))) begin
                cnt_r <= cnt_r - CW'(1);
                j_r   <= IW'(1);
              end else begin
                cnt_r   <= last_r ? '0 : cnt_r - CW'(1);
                state_r <= S_DONE;
              end
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!pend_v_r || q_ready) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("pending job left over in idle");
  a_pair_has_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAIR) |-> (cnt_r >= CW'(2)))
    else $error("pair pass with fewer than two peaks");
  a_pair_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAIR) |-> ((CW'(j_r) < cnt_r) && (j_r != '0)))
    else $error("follower index outside window");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && !pend_v_r) |=> (state_r == S_IDLE))
    else $error("done state did not return to idle");
`endif

endmodule

FILE: design/ppfh_back.sv
// ----------------------------------------------------------------------------
// ppfh_back
// Formats one pair job as decimal text and runs one SHA-1 block over it; error jobs skip hashing.
// ----------------------------------------------------------------------------
module ppfh_back #(
  parameter int TIME_BITS  = ppfh_pkg::TIME_BITS_DEF,
  parameter int FREQ_BITS  = ppfh_pkg::FREQ_BITS_DEF,
  parameter int HEX_DIGITS = ppfh_pkg::HEX_DIGITS_DEF,
  parameter int JW         = 2 * FREQ_BITS + 2 * TIME_BITS + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [JW-1:0]               q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ppfh_pkg::HASH_W-1:0] out_hash_value,
  output logic [TIME_BITS-1:0]        out_anchor_time,
  output logic                        out_order_error,
  output logic                        out_last_result
);

  import ppfh_pkg::*;

  localparam int NW  = (FREQ_BITS > TIME_BITS) ? FREQ_BITS : TIME_BITS;
  localparam int ND  = dec_digits(NW);
  localparam int BW  = ND * 4;
  localparam int DPW = $clog2(ND);
  localparam int NCW = $clog2(NW);
  localparam int HSH = 64 - 4 * HEX_DIGITS;

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_EMIT, S_SEP, S_PAD, S_ROUND, S_FIN} state_t;

  state_t               state_r;
  logic [FREQ_BITS-1:0] jf2_r;
  logic [TIME_BITS-1:0] jd_r;
  logic [TIME_BITS-1:0] jat_r;
  logic                 jerr_r;
  logic                 jlast_r;
  logic [1:0]           fld_r;
  logic [NW-1:0]        bin_r;
  logic [BW-1:0]        bcd_r;
  logic [NCW-1:0]       cnt_r;
  logic [DPW-1:0]       dp_r;
  logic                 started_r;
  logic [511:0]         blk_r;
  logic [6:0]           bc_r;
  logic [6:0]           len_r;
  logic [6:0]           rnd_r;
  logic [31:0]          a_r, b_r, c_r, d_r, e_r;
  logic                 out_valid_r;
  logic [HASH_W-1:0]    hash_r;
  logic [TIME_BITS-1:0] atime_r;
  logic                 err_r;
  logic                 lres_r;

  logic [BW-1:0]        adj;
  logic [3:0]           dig;
  logic                 emit_now;
  logic                 push;
  logic [7:0]           pbyte;
  logic [15:0]          len_bits;
  logic [31:0]          wcur;
  logic [31:0]          wx;
  logic [31:0]          wnew;
  logic [31:0]          ff;
  logic [31:0]          kk;
  logic [31:0]          tsum;
  logic [63:0]          top64;
  logic [63:0]          shifted;
  logic                 out_free;

  always_comb begin
    for (int k = 0; k < ND; k++) begin
      adj[4*k +: 4] = (bcd_r[4*k +: 4] >= 4'd5) ? bcd_r[4*k +: 4] + 4'd3 : bcd_r[4*k +: 4];
    end
  end

  assign dig      = bcd_r[{dp_r, 2'b00} +: 4];
  assign emit_now = (dig != 4'd0) || started_r || (dp_r == '0);
  assign len_bits = {6'd0, len_r, 3'b000};

  always_comb begin
    push  = 1'b0;
    pbyte = 8'h00;
    unique case (state_r)
      S_EMIT: begin
        push  = emit_now;
        pbyte = {4'h3, dig};
      end
      S_SEP: begin
        push  = 1'b1;
        pbyte = 8'h7C;
      end
      S_PAD: begin
        push = 1'b1;
        if (bc_r == len_r) begin
          pbyte = 8'h80;
        end else if (bc_r == 7'd62) begin
          pbyte = len_bits[15:8];
        end else if (bc_r == 7'd63) begin
          pbyte = len_bits[7:0];
        end
      end
      default: push = 1'b0;
    endcase
  end

  assign wcur = blk_r[511:480];
  assign wx   = blk_r[511-32*13 -: 32] ^ blk_r[511-32*8 -: 32] ^
                blk_r[511-32*2 -: 32] ^ blk_r[511:480];
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      ff = (b_r & c_r) | (~b_r & d_r);
      kk = SHA_K0;
    end else if (rnd_r < 7'd40) begin
      ff = b_r ^ c_r ^ d_r;
      kk = SHA_K1;
    end else if (rnd_r < 7'd60) begin
      ff = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      kk = SHA_K2;
    end else begin
      ff = b_r ^ c_r ^ d_r;
      kk = SHA_K3;
    end
  end

  assign tsum     = {a_r[26:0], a_r[31:27]} + ff + e_r + kk + wcur;
  assign top64    = {SHA_H0 + a_r, SHA_H1 + b_r};
  assign shifted  = top64 >> HSH;
  assign out_free = !out_valid_r || out_ready;

  assign q_ready         = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hash_value  = hash_r;
  assign out_anchor_time = atime_r;
  assign out_order_error = err_r;
  assign out_last_result = lres_r;

  always_ff @(posedge clk) begin
    if (push) begin
      blk_r <= {blk_r[503:0], pbyte};
    end else if (state_r == S_ROUND) begin
      blk_r <= {blk_r[479:0], wnew};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bc_r        <= '0;
      len_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        bc_r <= bc_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            jf2_r   <= q_data[2*FREQ_BITS-1:FREQ_BITS];
            jd_r    <= q_data[2*FREQ_BITS+TIME_BITS-1:2*FREQ_BITS];
            jat_r   <= q_data[2*FREQ_BITS+2*TIME_BITS-1:2*FREQ_BITS+TIME_BITS];
            jerr_r  <= q_data[JW-2];
            jlast_r <= q_data[JW-1];
            bin_r   <= NW'(q_data[FREQ_BITS-1:0]);
            bcd_r   <= '0;
            cnt_r   <= '0;
            fld_r   <= 2'd0;
            bc_r    <= '0;
            len_r   <= '0;
            state_r <= q_data[JW-2] ? S_FIN : S_CONV;
          end
        end
        S_CONV: begin
          bcd_r <= {adj[BW-2:0], bin_r[NW-1]};
          bin_r <= bin_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == NCW'(NW - 1)) begin
            dp_r      <= DPW'(ND - 1);
            started_r <= 1'b0;
            state_r   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_now) begin
            started_r <= 1'b1;
            len_r     <= len_r + 1'b1;
          end
          if (dp_r == '0) begin
            state_r <= (fld_r == 2'd2) ? S_PAD : S_SEP;
          end else begin
            dp_r <= dp_r - 1'b1;
          end
        end
        S_SEP: begin
          len_r   <= len_r + 1'b1;
          fld_r   <= fld_r + 1'b1;
          bin_r   <= (fld_r == 2'd0) ? NW'(jf2_r) : NW'(jd_r);
          bcd_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_CONV;
        end
        S_PAD: begin
          if (bc_r == 7'd63) begin
            a_r     <= SHA_H0;
            b_r     <= SHA_H1;
            c_r     <= SHA_H2;
            d_r     <= SHA_H3;
            e_r     <= SHA_H4;
            rnd_r   <= '0;
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          e_r   <= d_r;
          d_r   <= c_r;
          c_r   <= {b_r[1:0], b_r[31:2]};
          b_r   <= a_r;
          a_r   <= tsum;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 7'd79) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            hash_r      <= jerr_r ? '0 : shifted[HASH_W-1:0];
            atime_r     <= jerr_r ? '0 : jat_r;
            err_r       <= jerr_r;
            lres_r      <= jlast_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_round_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (bc_r == 7'd64))
    else $error("rounds started on a partly filled block");
  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (rnd_r <= 7'd79))
    else $error("round counter overran");
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("result overwrote one not yet taken");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak pair fingerprint hasher testbench
// Streams time-ordered peak tracks, with some out-of-order peaks mixed in,
// through the block under several delta bounds. Every word on the result side
// is checked against fingerprints computed here with a SHA-1 of our own.
// ----------------------------------------------------------------------------
module testbench;
  import ppfh_pkg::*;

  typedef struct {
    logic [HASH_W-1:0] hash_value;
    logic [15:0]       anchor_time;
    logic              order_error;
    logic              last_result;
  } fingerprint_t;

  class fingerprint_board;
    fingerprint_t expected_prints[$];
    logic [11:0]  win_freq[4];
    logic [15:0]  win_time[4];
    int           win_count;
    logic [15:0]  min_delta;
    logic [15:0]  max_delta;
    int           mismatches;
    int           checked;

    function new();
      win_count = 0;
      min_delta = MIN_DELTA_RST;
      max_delta = MAX_DELTA_RST;
      mismatches = 0;
      checked = 0;
    endfunction

    function logic [HASH_W-1:0] sha1_top40(string text);
      logic [7:0]  blk[64];
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      logic [63:0] top;
      int          len;
      len = text.len();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      for (int i = 0; i < len; i++) blk[i] = text[i];
      blk[len] = 8'h80;
      blk[62] = 8'((len * 8) >> 8);
      blk[63] = 8'(len * 8);
      for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 80; i++) begin
        t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {t[30:0], t[31]};
      end
      a = SHA_H0; b = SHA_H1; c = SHA_H2; d = SHA_H3; e = SHA_H4;
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = SHA_K0;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = SHA_K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = SHA_K2;
        end else begin
          f = b ^ c ^ d; k = SHA_K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      top = {SHA_H0 + a, SHA_H1 + b};
      return top[63:24];
    endfunction

    function void push_print(logic [HASH_W-1:0] h, logic [15:0] at, logic err);
      fingerprint_t p;
      p.hash_value = h;
      p.anchor_time = at;
      p.order_error = err;
      p.last_result = 1'b0;
      expected_prints.insert(expected_prints.size(), p);
    endfunction

    function void hash_pair(int ia, logic [11:0] f2, logic [15:0] t2);
      int delta;
      delta = int'(t2) - int'(win_time[ia]);
      if (delta < 0 || delta < min_delta || delta > max_delta) return;
      push_print(sha1_top40($sformatf("%0d|%0d|%0d", win_freq[ia], f2, delta)),
                 win_time[ia], 1'b0);
    endfunction

    function void note_peak(logic [11:0] fb, logic [15:0] tf, logic last);
      int  before_cnt;
      bit  bad;
      before_cnt = expected_prints.size();
      bad = 0;
      if (win_count > 0) begin
        if (tf < win_time[win_count-1] ||
            (tf == win_time[win_count-1] && fb < win_freq[win_count-1])) bad = 1;
      end
      if (bad) begin
        push_print('0, '0, 1'b1);
      end else begin
        if (win_count == 4) begin
          for (int j = 1; j < 4; j++) hash_pair(0, win_freq[j], win_time[j]);
          hash_pair(0, fb, tf);
          for (int j = 1; j < 4; j++) begin
            win_freq[j-1] = win_freq[j];
            win_time[j-1] = win_time[j];
          end
          win_count--;
        end
        win_freq[win_count] = fb;
        win_time[win_count] = tf;
        win_count++;
      end
      if (last) begin
        for (int i = 0; i < win_count; i++)
          for (int j = i + 1; j < win_count; j++) hash_pair(i, win_freq[j], win_time[j]);
        win_count = 0;
      end
      if (expected_prints.size() > before_cnt)
        expected_prints[expected_prints.size()-1].last_result = 1'b1;
    endfunction

    function void check_result(fingerprint_t got);
      fingerprint_t exp_p;
      checked++;
      if (expected_prints.size() == 0) begin
        $error("Unexpected result word: hash %h anchor %0d", got.hash_value, got.anchor_time);
        mismatches++;
        return;
      end
      exp_p = expected_prints.pop_front();
      if (got.hash_value !== exp_p.hash_value) begin
        $error("hash_value: expected %h, got %h", exp_p.hash_value, got.hash_value);
        mismatches++;
      end
      if (got.anchor_time !== exp_p.anchor_time) begin
        $error("anchor_time: expected %0d, got %0d", exp_p.anchor_time, got.anchor_time);
        mismatches++;
      end
      if (got.order_error !== exp_p.order_error) begin
        $error("order_error: expected %0d, got %0d", exp_p.order_error, got.order_error);
        mismatches++;
      end
      if (got.last_result !== exp_p.last_result) begin
        $error("last_result: expected %0d, got %0d", exp_p.last_result, got.last_result);
        mismatches++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 4000000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [11:0]          in_freq_bin;
  logic [15:0]          in_time_frame;
  logic                 in_last_peak;
  logic                 out_valid;
  logic                 out_ready;
  logic [HASH_W-1:0]    out_hash_value;
  logic [15:0]          out_anchor_time;
  logic                 out_order_error;
  logic                 out_last_result;

  fingerprint_board board;
  int               cycles = 0;
  int               peaks_sent;
  int               error_peaks;

  peak_pair_fingerprint_hasher uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_freq_bin(in_freq_bin),
    .in_time_frame(in_time_frame), .in_last_peak(in_last_peak),
    .out_valid(out_valid), .out_ready(out_ready), .out_hash_value(out_hash_value),
    .out_anchor_time(out_anchor_time), .out_order_error(out_order_error),
    .out_last_result(out_last_result)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    fingerprint_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      got.hash_value = out_hash_value;
      got.anchor_time = out_anchor_time;
      got.order_error = out_order_error;
      got.last_result = out_last_result;
      board.check_result(got);
    end
    if (!rst_n) out_ready <= 1'b0;
    else if ((cycles / 2000) % 4 == 3) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 70);
  end

  task automatic send_peak(logic [11:0] fb, logic [15:0] tf, logic last);
    int gap;
    in_valid <= 1'b1;
    in_freq_bin <= fb;
    in_time_frame <= tf;
    in_last_peak <= last;
    do @(posedge clk); while (!in_ready);
    board.note_peak(fb, tf, last);
    peaks_sent++;
    gap = ((cycles / 3000) % 3 == 2) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_prints.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_DELTA) board.min_delta = val;
    else board.max_delta = val;
  endtask

  task automatic set_bounds(logic [15:0] lo, logic [15:0] hi);
    wait_idle();
    write_reg(CFG_MIN_DELTA, lo);
    write_reg(CFG_MAX_DELTA, hi);
  endtask

  task automatic send_track(int len);
    logic [11:0] fb;
    logic [15:0] tf;
    int          r;
    int          step;
    fb = 12'($urandom_range(0, 4095));
    tf = 16'($urandom_range(0, 65535));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0 && r < 6 && (tf > 0 || fb > 0)) begin
        error_peaks++;
        if (tf > 0) send_peak(12'($urandom_range(0, 4095)),
                              16'(tf - $urandom_range(1, tf < 50 ? tf : 50)),
                              i == len - 1);
        else send_peak(12'($urandom_range(0, fb - 1)), tf, i == len - 1);
      end else begin
        if (i > 0) begin
          r = $urandom_range(0, 99);
          step = (r < 20) ? 0 : (r < 85) ? $urandom_range(1, 60) : $urandom_range(100, 400);
          if (int'(tf) + step > 65535) step = 0;
          if (step == 0 && fb == 12'hfff) step = (tf < 65535) ? 1 : 0;
          if (step == 0) fb = 12'($urandom_range(fb, 4095));
          else fb = 12'($urandom_range(0, 4095));
          tf = 16'(tf + step);
        end
        send_peak(fb, tf, i == len - 1);
      end
    end
  endtask

  task automatic random_phase(int count);
    int target;
    target = peaks_sent + count;
    while (peaks_sent < target) send_track($urandom_range(1, 12));
  endtask

  initial begin
    board = new();
    peaks_sent = 0;
    error_peaks = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_DELTA;
    cfg_data = '0;
    in_valid = 1'b0;
    in_freq_bin = '0;
    in_time_frame = '0;
    in_last_peak = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset bounds, a full window sliding over, then flushed.
    for (int i = 0; i < 6; i++) send_peak(12'(i * 700), 16'(i * 3 + 1), i == 5);
    set_bounds(16'd0, 16'hffff);
    send_peak(12'd0, 16'd0, 1'b0);
    send_peak(12'hfff, 16'd0, 1'b0);
    send_peak(12'd100, 16'd0, 1'b0);
    send_peak(12'd5, 16'hffff, 1'b0);
    send_peak(12'hfff, 16'hffff, 1'b1);
    send_peak(12'd7, 16'd10, 1'b1);
    send_peak(12'd10, 16'd500, 1'b0);
    send_peak(12'd11, 16'd400, 1'b1);
    send_peak(12'd3, 16'd20, 1'b0);
    send_peak(12'd2, 16'd20, 1'b0);
    send_peak(12'd9, 16'd21, 1'b1);
    error_peaks += 3;

    random_phase(70);
    set_bounds(16'd5, 16'd40);
    random_phase(70);
    set_bounds(16'd300, 16'd100);
    random_phase(40);
    set_bounds(16'hffff, 16'hffff);
    send_peak(12'd1, 16'd0, 1'b0);
    send_peak(12'd2, 16'hffff, 1'b1);
    random_phase(30);
    set_bounds(16'd0, 16'd0);
    random_phase(50);
    set_bounds(MIN_DELTA_RST, MAX_DELTA_RST);
    random_phase(70);

    wait_idle();
    $display("Sent %0d peaks (%0d out of order) under six delta bound settings.",
             peaks_sent, error_peaks);
    $display("Checked %0d result words, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: peak_pair_fingerprint_hasher.f
design/ppfh_pkg.sv
design/ppfh_queue.sv
design/ppfh_front.sv
design/ppfh_back.sv
design/peak_pair_fingerprint_hasher.sv
verif/testbench.sv
